FILE: design/utwk_pkg.sv
package utwk_pkg;

    // Default table depths
    localparam int GLYPH_ENTRIES_DEF = 256;
    localparam int KERN_ENTRIES_DEF  = 256;

    // Field widths
    localparam int CODE_W  = 21;
    localparam int ADV_W   = 16;
    localparam int SUM_W   = 32;
    localparam int BYTE_W  = 8;
    localparam int SLOT_W  = 8;

    // Saturation limits of the Q20.12 sum
    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // UTF-8 lead and continuation byte patterns
    localparam logic [BYTE_W-1:0] ASCII_MASK = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_TAG  = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD2_BITS = 8'h1F;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_TAG  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD3_BITS = 8'h0F;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_TAG  = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD4_BITS = 8'h07;
    localparam logic [BYTE_W-1:0] CONT_BITS  = 8'h3F;

    // Item function codes
    typedef enum logic [1:0] {
        FUNC_TEXT  = 2'd0,
        FUNC_GLYPH = 2'd1,
        FUNC_KERN  = 2'd2,
        FUNC_CLEAR = 2'd3
    } t_func;

    typedef struct packed {
        t_func                    func;
        logic [BYTE_W-1:0]        text_byte;
        logic                     last_byte;
        logic [SLOT_W-1:0]        slot;
        logic [CODE_W-1:0]        first_code;
        logic [CODE_W-1:0]        second_code;
        logic signed [ADV_W-1:0]  advance_value;
    } t_in_item;

    typedef struct packed {
        logic signed [SUM_W-1:0]  text_width;
        logic                     width_saturated;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic exec;
        logic scan_clr;
        logic scan_k;
        logic scan_g;
        logic add;
        logic set_prev;
        logic emit;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        t_func func;
        logic  last;
        logic  acct;
        logic  prev_nz;
        logic  k_hit;
        logic  g_hit;
        logic  k_end;
        logic  g_end;
    } t_sts;

endpackage

FILE: design/utwk_ctrl.sv
module utwk_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  utwk_pkg::t_sts  i_sts,
    output utwk_pkg::t_cmd  o_cmd,
    output logic            o_busy
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_EXEC   = 5'b00010,
        ST_KSCAN  = 5'b00100,
        ST_GSCAN  = 5'b01000,
        ST_FINISH = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Sequence one item: decode or table write, kerning scan, glyph scan, result
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.load = i_start;
                if (i_start) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec     = 1'b1;
                o_cmd.scan_clr = 1'b1;
                if (i_sts.func != utwk_pkg::FUNC_TEXT) begin
                    n_state = ST_IDLE;
                end else if (i_sts.acct) begin
                    n_state = i_sts.prev_nz ? ST_KSCAN : ST_GSCAN;
                end else if (i_sts.last) begin
                    n_state = ST_FINISH;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_KSCAN: begin
                o_cmd.scan_k = 1'b1;
                if (i_sts.k_hit || i_sts.k_end) begin
                    o_cmd.add      = i_sts.k_hit;
                    o_cmd.scan_clr = 1'b1;
                    n_state        = ST_GSCAN;
                end
            end
            ST_GSCAN: begin
                o_cmd.scan_g = 1'b1;
                if (i_sts.g_hit || i_sts.g_end) begin
                    o_cmd.add      = i_sts.g_hit;
                    o_cmd.set_prev = 1'b1;
                    n_state        = i_sts.last ? ST_FINISH : ST_IDLE;
                end
            end
            ST_FINISH: begin
                o_cmd.emit = 1'b1;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

FILE: design/utwk_dpath.sv
module utwk_dpath #(
    parameter int GLYPH_ENTRIES = utwk_pkg::GLYPH_ENTRIES_DEF,
    parameter int KERN_ENTRIES  = utwk_pkg::KERN_ENTRIES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  utwk_pkg::t_in_item  i_item,
    input  utwk_pkg::t_cmd      i_cmd,
    output utwk_pkg::t_sts      o_sts,
    output utwk_pkg::t_out_item o_result,
    output logic                o_result_valid
);

    localparam int GIW = (GLYPH_ENTRIES > 1) ? $clog2(GLYPH_ENTRIES) : 1;
    localparam int KIW = (KERN_ENTRIES > 1) ? $clog2(KERN_ENTRIES) : 1;
    localparam int SIW = (GIW > KIW) ? GIW : KIW;
    localparam logic [SIW-1:0] GLAST = SIW'(GLYPH_ENTRIES - 1);
    localparam logic [SIW-1:0] KLAST = SIW'(KERN_ENTRIES - 1);
    localparam int CW = utwk_pkg::CODE_W;
    localparam int AW = utwk_pkg::ADV_W;
    localparam int SW = utwk_pkg::SUM_W;
    localparam int BYTE_W_L = utwk_pkg::BYTE_W;

    typedef struct packed {
        logic [CW-1:0]        code;
        logic signed [AW-1:0] adv;
    } t_glyph_ent;

    typedef struct packed {
        logic [CW-1:0]        first;
        logic [CW-1:0]        second;
        logic signed [AW-1:0] adjust;
    } t_kern_ent;

    // Add one entry to the sum, clamping to the Q20.12 range
    function automatic logic [SW:0] f_sat_add(input logic [SW-1:0] a,
                                              input logic [AW-1:0] d);
        logic [SW:0] s;
        s = {a[SW-1], a} + {{(SW-AW+1){d[AW-1]}}, d};
        if (s[SW] != s[SW-1]) begin
            return {1'b1, s[SW] ? utwk_pkg::SUM_MIN : utwk_pkg::SUM_MAX};
        end
        return {1'b0, s[SW-1:0]};
    endfunction

    utwk_pkg::t_in_item r_item;

    t_glyph_ent r_gmem [GLYPH_ENTRIES];
    t_kern_ent  r_kmem [KERN_ENTRIES];
    logic [GLYPH_ENTRIES-1:0] r_gvalid;
    logic [KERN_ENTRIES-1:0]  r_kvalid;

    t_glyph_ent r_gq;
    t_kern_ent  r_kq;
    logic       r_gv_q;
    logic       r_kv_q;

    logic [SIW-1:0] r_idx;
    logic [SIW-1:0] r_cmp_idx;
    logic           r_live;

    logic [1:0]    r_pend;
    logic [CW-1:0] r_part;
    logic [CW-1:0] r_prev;
    logic [CW-1:0] r_code;
    logic [SW-1:0] r_sum;
    logic          r_clip;

    utwk_pkg::t_out_item r_out;
    logic                r_out_vld;

    logic [1:0]    d_pend;
    logic [CW-1:0] d_part;
    logic [CW-1:0] d_code;
    logic [CW-1:0] d_cont;
    logic          d_acct;
    logic [BYTE_W_L-1:0] d_byte;

    logic          k_hit;
    logic          g_hit;
    logic [SW:0]   add_res;
    logic [AW-1:0] add_delta;
    logic          wr_glyph;
    logic          wr_kern;

    // Capture the item on transfer
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
    end

    // Decode one text byte against the pending sequence
    always_comb begin
        d_byte = r_item.text_byte;
        d_pend = r_pend;
        d_part = r_part;
        d_acct = 1'b0;
        d_code = r_part;
        d_cont = CW'(d_byte & utwk_pkg::CONT_BITS);
        if (r_pend != 2'd0) begin
            d_pend = r_pend - 2'd1;
            case (d_pend)
                2'd0:    d_part = r_part | d_cont;
                2'd1:    d_part = r_part | (d_cont << 6);
                default: d_part = r_part | (d_cont << 12);
            endcase
            if (d_pend == 2'd0) begin
                d_acct = 1'b1;
                d_code = d_part;
            end
        end else if ((d_byte & utwk_pkg::ASCII_MASK) == '0) begin
            d_acct = 1'b1;
            d_code = CW'(d_byte);
        end else if ((d_byte & utwk_pkg::LEAD2_MASK) == utwk_pkg::LEAD2_TAG) begin
            d_part = CW'(d_byte & utwk_pkg::LEAD2_BITS) << 6;
            d_pend = 2'd1;
        end else if ((d_byte & utwk_pkg::LEAD3_MASK) == utwk_pkg::LEAD3_TAG) begin
            d_part = CW'(d_byte & utwk_pkg::LEAD3_BITS) << 12;
            d_pend = 2'd2;
        end else if ((d_byte & utwk_pkg::LEAD4_MASK) == utwk_pkg::LEAD4_TAG) begin
            d_part = CW'(d_byte & utwk_pkg::LEAD4_BITS) << 18;
            d_pend = 2'd3;
        end
        // Complete a sequence cut short by the last byte with zero bits
        if (r_item.last_byte && (d_pend != 2'd0)) begin
            d_acct = 1'b1;
            d_code = d_part;
            d_pend = 2'd0;
        end
    end

    assign wr_glyph = i_cmd.exec && (r_item.func == utwk_pkg::FUNC_GLYPH)
                      && (int'(r_item.slot) < GLYPH_ENTRIES);
    assign wr_kern  = i_cmd.exec && (r_item.func == utwk_pkg::FUNC_KERN)
                      && (int'(r_item.slot) < KERN_ENTRIES);

    // Table memories: one write port, one registered read port each
    always_ff @(posedge i_clk) begin
        if (wr_glyph) begin
            r_gmem[GIW'(r_item.slot)] <= '{code: r_item.first_code,
                                           adv:  r_item.advance_value};
        end
        r_gq <= r_gmem[GIW'(r_idx)];
    end

    always_ff @(posedge i_clk) begin
        if (wr_kern) begin
            r_kmem[KIW'(r_item.slot)] <= '{first:  r_item.first_code,
                                           second: r_item.second_code,
                                           adjust: r_item.advance_value};
        end
        r_kq <= r_kmem[KIW'(r_idx)];
    end

    // Valid bits, cleared by reset and by the clear function
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gvalid <= '0;
            r_kvalid <= '0;
        end else if (i_cmd.exec && (r_item.func == utwk_pkg::FUNC_CLEAR)) begin
            r_gvalid <= '0;
            r_kvalid <= '0;
        end else begin
            if (wr_glyph) begin
                r_gvalid[GIW'(r_item.slot)] <= 1'b1;
            end
            if (wr_kern) begin
                r_kvalid[KIW'(r_item.slot)] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_gv_q <= r_gvalid[GIW'(r_idx)];
        r_kv_q <= r_kvalid[KIW'(r_idx)];
    end

    // Scan pointer: issue one address a cycle, compare the one before
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_cmp_idx <= '0;
            r_live    <= 1'b0;
        end else if (i_cmd.scan_clr) begin
            r_idx  <= '0;
            r_live <= 1'b0;
        end else if (i_cmd.scan_k || i_cmd.scan_g) begin
            if (r_idx == (i_cmd.scan_k ? KLAST : GLAST)) begin
                r_idx <= '0;
            end else begin
                r_idx <= r_idx + SIW'(1);
            end
            r_cmp_idx <= r_idx;
            r_live    <= 1'b1;
        end
    end

    assign k_hit = r_live && r_kv_q && (r_kq.first == r_prev) && (r_kq.second == r_code);
    assign g_hit = r_live && r_gv_q && (r_gq.code == r_code);

    assign add_delta = i_cmd.scan_k ? r_kq.adjust : r_gq.adv;
    assign add_res   = f_sat_add(r_sum, add_delta);

    // String state: decoder, previous codepoint, running sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_part <= '0;
            r_prev <= '0;
            r_sum  <= '0;
            r_clip <= 1'b0;
        end else if (i_cmd.emit) begin
            r_pend <= '0;
            r_part <= '0;
            r_prev <= '0;
            r_sum  <= '0;
            r_clip <= 1'b0;
        end else begin
            if (i_cmd.exec && (r_item.func == utwk_pkg::FUNC_TEXT)) begin
                r_pend <= d_pend;
                r_part <= d_part;
            end
            if (i_cmd.set_prev) begin
                r_prev <= r_code;
            end
            if (i_cmd.add) begin
                r_sum  <= add_res[SW-1:0];
                r_clip <= r_clip | add_res[SW];
            end
        end
    end

    // Hold the codepoint being accounted
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && d_acct) begin
            r_code <= d_code;
        end
    end

    // Result register and strobe
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out <= '{text_width: r_sum, width_saturated: r_clip};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= i_cmd.emit;
        end
    end

    always_comb begin
        o_sts.func    = r_item.func;
        o_sts.last    = r_item.last_byte;
        o_sts.acct    = d_acct;
        o_sts.prev_nz = (r_prev != '0);
        o_sts.k_hit   = k_hit;
        o_sts.g_hit   = g_hit;
        o_sts.k_end   = r_live && (r_cmp_idx == KLAST);
        o_sts.g_end   = r_live && (r_cmp_idx == GLAST);
    end

    assign o_result       = r_out;
    assign o_result_valid = r_out_vld;

endmodule

FILE: design/utf8_text_width_with_kerning.sv
// UTF-8 string width with glyph advances and pair kerning. Items are taken on
// start while busy is low; func selects a text byte, a glyph table write, a
// kerning table write or a clear of both tables. A table write or clear
// passes through the exec state alone, and so does a text byte that
// completes no codepoint, but for the last byte, which then passes through
// the finish state too. A byte that completes a codepoint searches the
// kerning table (only when the previous codepoint is nonzero) and then the
// glyph table, one entry per cycle through each table's read port, stopping
// at the first match. The width of a string is shown on o_result for exactly
// one cycle with o_result_valid high, registered from the emit in the finish
// state that ends the last byte's work; the receiver cannot stall it and
// must take it then.
module utf8_text_width_with_kerning #(
    parameter int GLYPH_ENTRIES = utwk_pkg::GLYPH_ENTRIES_DEF,
    parameter int KERN_ENTRIES  = utwk_pkg::KERN_ENTRIES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  utwk_pkg::t_in_item  i_item,
    output utwk_pkg::t_out_item o_result,
    output logic                o_result_valid
);

    utwk_pkg::t_cmd w_cmd;
    utwk_pkg::t_sts w_sts;

    utwk_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    utwk_dpath #(
        .GLYPH_ENTRIES (GLYPH_ENTRIES),
        .KERN_ENTRIES  (KERN_ENTRIES)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (i_item),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_result       (o_result),
        .o_result_valid (o_result_valid)
    );

    // A result strobe follows exactly one emit command
    a_emit_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |=> o_result_valid)
        else $error("result strobe missing after emit");

    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(w_cmd.emit))
        else $error("result strobe without emit");

    // Only one table is scanned at a time
    a_one_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.scan_k && w_cmd.scan_g))
        else $error("both tables scanned at once");

    // An addition happens only on a hit in the table being scanned
    a_add_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.add |-> (w_cmd.scan_k ? w_sts.k_hit : w_sts.g_hit))
        else $error("sum updated without a table hit");

endmodule
